@@ sv/rpc_pkg.sv @@
// shared types and constants for the rectangle polygon clipper
package rpc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int CFG_BITS       = 16;
   localparam int NUM_STAGES     = 4;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_X_MIN = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_MAX = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_MIN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_MAX = 3'd3;

   localparam logic signed [CFG_BITS-1:0] X_MIN_RST = 16'sd0;
   localparam logic signed [CFG_BITS-1:0] X_MAX_RST = 16'sd511;
   localparam logic signed [CFG_BITS-1:0] Y_MIN_RST = 16'sd0;
   localparam logic signed [CFG_BITS-1:0] Y_MAX_RST = 16'sd511;

   localparam int STAGE_LEFT   = 0;
   localparam int STAGE_TOP    = 1;
   localparam int STAGE_RIGHT  = 2;
   localparam int STAGE_BOTTOM = 3;

   typedef struct packed {
      logic vert;
      logic fin;
   } rpc_flags_type;

endpackage

@@ sv/rpc_clip_cell.sv @@
// one half-plane clipping cell with its own multiplier and restoring divider
module rpc_clip_cell import rpc_pkg::*; #(
   parameter int CW    = 16,
   parameter int STAGE = STAGE_LEFT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [CFG_BITS-1:0] bound,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  logic signed [CW-1:0]       in_x,
   input  logic signed [CW-1:0]       in_y,
   input  rpc_flags_type              in_flags,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic signed [CW-1:0]       out_x,
   output logic signed [CW-1:0]       out_y,
   output rpc_flags_type              out_flags
);

   localparam int   DW      = CW + 1;
   localparam int   PW      = 2 * DW;
   localparam int   CNTW    = $clog2(DW + 1);
   localparam logic AXIS_X  = (STAGE == STAGE_LEFT) || (STAGE == STAGE_RIGHT);
   localparam logic KEEP_GE = (STAGE == STAGE_LEFT) || (STAGE == STAGE_BOTTOM);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_VTX   = 9'b000000010,
      ST_FIN   = 9'b000000100,
      ST_EDGE  = 9'b000001000,
      ST_MUL   = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_EMITX = 9'b001000000,
      ST_EMITQ = 9'b010000000,
      ST_END   = 9'b100000000
   } rpc_cell_state_type;

   function automatic logic inside_f(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                     logic signed [CW-1:0] c);
      logic signed [CW-1:0] u;
      u = AXIS_X ? x : y;
      return KEEP_GE ? (u >= c) : (u <= c);
   endfunction

   rpc_cell_state_type state_ff, state_in;
   logic seen_ff, seen_in;
   logic signed [CW-1:0] tok_x_ff, tok_x_in, tok_y_ff, tok_y_in;
   rpc_flags_type tok_flags_ff, tok_flags_in;
   logic signed [CW-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic signed [CW-1:0] q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic signed [CW-1:0] w1_ff, w1_in;
   logic qin_ff, qin_in, neg_ff, neg_in;
   logic [DW-1:0] du_mag_ff, du_mag_in, dt_mag_ff, dt_mag_in, dw_mag_ff, dw_mag_in;
   logic [DW-1:0] rem_ff, rem_in, low_ff, low_in, quot_ff, quot_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   logic signed [CW-1:0] c_w, p_u, p_w, q_u, q_w;
   logic signed [DW-1:0] du, dt, dw;
   logic pin, qin;
   logic [PW-1:0] prod;
   logic [DW:0] shifted;
   logic ge;
   logic [DW-1:0] cross_w;

   assign c_w = CW'(bound);
   assign p_u = AXIS_X ? p_x_ff : p_y_ff;
   assign p_w = AXIS_X ? p_y_ff : p_x_ff;
   assign q_u = AXIS_X ? q_x_ff : q_y_ff;
   assign q_w = AXIS_X ? q_y_ff : q_x_ff;
   assign du  = DW'(q_u) - DW'(p_u);
   assign dt  = DW'(c_w) - DW'(p_u);
   assign dw  = DW'(q_w) - DW'(p_w);
   assign pin = inside_f(p_x_ff, p_y_ff, c_w);
   assign qin = inside_f(q_x_ff, q_y_ff, c_w);
   assign prod = dw_mag_ff * dt_mag_ff;
   assign shifted = {rem_ff, low_ff[DW-1]};
   assign ge = shifted >= {1'b0, du_mag_ff};
   assign cross_w = neg_ff ? (DW'(w1_ff) - quot_ff) : (DW'(w1_ff) + quot_ff);

   assign in_stall  = (state_ff != ST_IDLE);
   assign out_valid = state_ff inside {ST_EMITX, ST_EMITQ, ST_END};

   always_comb begin
      out_x = q_x_ff;
      out_y = q_y_ff;
      out_flags = '{vert: 1'b1, fin: 1'b0};
      case (state_ff)
         ST_EMITX: begin
            out_x = AXIS_X ? c_w : CW'(cross_w);
            out_y = AXIS_X ? CW'(cross_w) : c_w;
         end
         ST_END: begin
            out_flags = '{vert: 1'b0, fin: 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      seen_in = seen_ff;
      tok_x_in = tok_x_ff;
      tok_y_in = tok_y_ff;
      tok_flags_in = tok_flags_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      p_x_in = p_x_ff;
      p_y_in = p_y_ff;
      q_x_in = q_x_ff;
      q_y_in = q_y_ff;
      w1_in = w1_ff;
      qin_in = qin_ff;
      neg_in = neg_ff;
      du_mag_in = du_mag_ff;
      dt_mag_in = dt_mag_ff;
      dw_mag_in = dw_mag_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      quot_in = quot_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               tok_x_in = in_x;
               tok_y_in = in_y;
               tok_flags_in = in_flags;
               state_in = ST_VTX;
            end
         end
         ST_VTX: begin
            state_in = ST_FIN;
            if (tok_flags_ff.vert) begin
               prev_x_in = tok_x_ff;
               prev_y_in = tok_y_ff;
               if (seen_ff) begin
                  p_x_in = prev_x_ff;
                  p_y_in = prev_y_ff;
                  q_x_in = tok_x_ff;
                  q_y_in = tok_y_ff;
                  state_in = ST_EDGE;
               end else begin
                  first_x_in = tok_x_ff;
                  first_y_in = tok_y_ff;
                  seen_in = 1'b1;
               end
            end
         end
         ST_FIN: begin
            if (tok_flags_ff.fin && seen_ff) begin
               p_x_in = prev_x_ff;
               p_y_in = prev_y_ff;
               q_x_in = first_x_ff;
               q_y_in = first_y_ff;
               seen_in = 1'b0;
               state_in = ST_EDGE;
            end else if (tok_flags_ff.fin) begin
               state_in = ST_END;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE: begin
            qin_in = qin;
            neg_in = du[DW-1] ^ dt[DW-1] ^ dw[DW-1];
            w1_in = p_w;
            du_mag_in = du[DW-1] ? (~du + 1'b1) : du;
            dt_mag_in = dt[DW-1] ? (~dt + 1'b1) : dt;
            dw_mag_in = dw[DW-1] ? (~dw + 1'b1) : dw;
            if (pin != qin) begin
               state_in = ST_MUL;
            end else if (qin) begin
               state_in = ST_EMITQ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            rem_in = prod[PW-1:DW];
            low_in = prod[DW-1:0];
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? DW'(shifted - {1'b0, du_mag_ff}) : shifted[DW-1:0];
            low_in = low_ff << 1;
            quot_in = {quot_ff[DW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(DW - 1)) begin
               state_in = ST_EMITX;
            end
         end
         ST_EMITX: begin
            if (!out_stall) begin
               state_in = qin_ff ? ST_EMITQ : ST_FIN;
            end
         end
         ST_EMITQ: begin
            if (!out_stall) begin
               state_in = ST_FIN;
            end
         end
         ST_END: begin
            if (!out_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_x_ff <= tok_x_in;
      tok_y_ff <= tok_y_in;
      tok_flags_ff <= tok_flags_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
      w1_ff <= w1_in;
      qin_ff <= qin_in;
      neg_ff <= neg_in;
      du_mag_ff <= du_mag_in;
      dt_mag_ff <= dt_mag_in;
      dw_mag_ff <= dw_mag_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quot_ff <= quot_in;
      cnt_ff <= cnt_in;
   end

endmodule

@@ sv/rpc_sink.sv @@
// hold stage and output register that marks the final vertex of a polygon
module rpc_sink import rpc_pkg::*; #(
   parameter int CW         = 16,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic signed [CW-1:0]         in_x,
   input  logic signed [CW-1:0]         in_y,
   input  rpc_flags_type                in_flags,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_out_last,
   output logic                         rsp_no_vertex
);

   logic rsp_valid_ff, rsp_valid_in, hold_v_ff, hold_v_in;
   logic signed [CW-1:0] hold_x_ff, hold_x_in, hold_y_ff, hold_y_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic last_ff, last_in, none_ff, none_in;
   logic accept;

   assign in_stall = rsp_valid_ff & rsp_stall;
   assign accept = in_valid & !in_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_out_last = last_ff;
   assign rsp_no_vertex = none_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      hold_v_in = hold_v_ff;
      hold_x_in = hold_x_ff;
      hold_y_in = hold_y_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      last_in = last_ff;
      none_in = none_ff;
      if (accept) begin
         if (in_flags.vert) begin
            if (hold_v_ff) begin
               rsp_valid_in = 1'b1;
               out_x_in = COORD_BITS'(hold_x_ff);
               out_y_in = COORD_BITS'(hold_y_ff);
               last_in = 1'b0;
               none_in = 1'b0;
            end
            hold_x_in = in_x;
            hold_y_in = in_y;
            hold_v_in = 1'b1;
         end else if (in_flags.fin) begin
            rsp_valid_in = 1'b1;
            last_in = 1'b1;
            none_in = !hold_v_ff;
            out_x_in = hold_v_ff ? COORD_BITS'(hold_x_ff) : '0;
            out_y_in = hold_v_ff ? COORD_BITS'(hold_y_ff) : '0;
            hold_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_x_ff <= hold_x_in;
      hold_y_ff <= hold_y_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      last_ff <= last_in;
      none_ff <= none_in;
   end

endmodule

@@ sv/rect_polygon_clipper.sv @@
// top level of the rectangle polygon clipper: window registers, cell chain and sink
//
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   vert_x, vert_y, last_vertex
// rsp      out        rsp_valid/rsp_stall   out_x, out_y, out_last, no_vertex
// csr      in         csr_wr_en             csr_index, csr_wdata
//
// each cell takes one token at a time: a first vertex passes IDLE, VTX and FIN;
// each later edge adds EDGE, a kept vertex adds EMITQ, and a crossing adds MUL,
// the DIV steps (one restoring divider bit per cycle over max(COORD_BITS,16)+1
// bits) and EMITX; on the last vertex the closing edge runs the same steps again
// plus END for the end marker. the busiest cell sets the rate.
// synchronous reset drops any polygon in progress.
// a stalled rsp holds the chain back one cell at a time; no clearing pass.
module rect_polygon_clipper import rpc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vert_x,
   input  logic signed [COORD_BITS-1:0] req_vert_y,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_out_last,
   output logic                         rsp_no_vertex,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [CFG_BITS-1:0]          csr_wdata
);

   localparam int CW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

   logic signed [CFG_BITS-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic signed [CFG_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [CFG_BITS-1:0] bound [NUM_STAGES];

   logic                 lk_valid [NUM_STAGES+1];
   logic                 lk_stall [NUM_STAGES+1];
   logic signed [CW-1:0] lk_x     [NUM_STAGES+1];
   logic signed [CW-1:0] lk_y     [NUM_STAGES+1];
   rpc_flags_type        lk_flags [NUM_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= X_MIN_RST;
         x_max_ff <= X_MAX_RST;
         y_min_ff <= Y_MIN_RST;
         y_max_ff <= Y_MAX_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_MIN: x_min_ff <= csr_wdata;
            CSR_X_MAX: x_max_ff <= csr_wdata;
            CSR_Y_MIN: y_min_ff <= csr_wdata;
            CSR_Y_MAX: y_max_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign lo_x = (x_min_ff < x_max_ff) ? x_min_ff : x_max_ff;
   assign hi_x = (x_min_ff < x_max_ff) ? x_max_ff : x_min_ff;
   assign lo_y = (y_min_ff < y_max_ff) ? y_min_ff : y_max_ff;
   assign hi_y = (y_min_ff < y_max_ff) ? y_max_ff : y_min_ff;

   assign bound[STAGE_LEFT]   = lo_x;
   assign bound[STAGE_TOP]    = hi_y;
   assign bound[STAGE_RIGHT]  = hi_x;
   assign bound[STAGE_BOTTOM] = lo_y;

   assign lk_valid[0] = req_valid;
   assign req_stall   = lk_stall[0];
   assign lk_x[0]     = CW'(req_vert_x);
   assign lk_y[0]     = CW'(req_vert_y);
   assign lk_flags[0] = '{vert: 1'b1, fin: req_last_vertex};

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
      rpc_clip_cell #(
         .CW    (CW),
         .STAGE (s)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bound     (bound[s]),
         .in_valid  (lk_valid[s]),
         .in_stall  (lk_stall[s]),
         .in_x      (lk_x[s]),
         .in_y      (lk_y[s]),
         .in_flags  (lk_flags[s]),
         .out_valid (lk_valid[s+1]),
         .out_stall (lk_stall[s+1]),
         .out_x     (lk_x[s+1]),
         .out_y     (lk_y[s+1]),
         .out_flags (lk_flags[s+1])
      );
   end

   rpc_sink #(
      .CW         (CW),
      .COORD_BITS (COORD_BITS)
   ) u_sink (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (lk_valid[NUM_STAGES]),
      .in_stall      (lk_stall[NUM_STAGES]),
      .in_x          (lk_x[NUM_STAGES]),
      .in_y          (lk_y[NUM_STAGES]),
      .in_flags      (lk_flags[NUM_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_last  (rsp_out_last),
      .rsp_no_vertex (rsp_no_vertex)
   );

endmodule

@@ test/tb.sv @@
// self-checking testbench for the rectangle polygon clipper
module tb import rpc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd5;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
      logic      none;
   } clip_vertex_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } poly_vertex_type;
   typedef struct {
      poly_vertex_type v;
      logic            chk;
      clip_vertex_type exp;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   coord_type req_vert_x = '0;
   coord_type req_vert_y = '0;
   logic req_last_vertex = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   coord_type rsp_out_x;
   coord_type rsp_out_y;
   logic rsp_out_last;
   logic rsp_no_vertex;
   logic csr_wr_en = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   always #4 clock = ~clock;

   rect_polygon_clipper #(.COORD_BITS(CB)) DUT (.*);

   // predictor state
   longint win_xlo, win_xhi, win_ylo, win_yhi;
   logic signed [CFG_BITS-1:0] reg_xmin, reg_xmax, reg_ymin, reg_ymax;
   longint fx[NUM_STAGES], fy[NUM_STAGES], px[NUM_STAGES], py[NUM_STAGES];
   bit seen[NUM_STAGES], emitted[NUM_STAGES];
   longint hold_x, hold_y;

   clip_vertex_type clipped_q[$];
   logic fixed_q[$];
   clip_vertex_type fixed_val_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit long_hold = 0;
   stim_row_type rows[$];

   function automatic longint cross_at(longint u1, longint w1, longint u2, longint w2,
                                       longint c);
      longint du, dt, dw, m;
      du = u2 - u1;
      dt = c - u1;
      dw = w2 - w1;
      if (du == 0) return w1;
      m = ((dw < 0 ? -dw : dw) * (dt < 0 ? -dt : dt)) / (du < 0 ? -du : du);
      return (((dw < 0) != (dt < 0)) != (du < 0)) ? w1 - m : w1 + m;
   endfunction

   function automatic bit in_half(int s, longint x, longint y);
      case (s)
         STAGE_LEFT: return x >= win_xlo;
         STAGE_TOP: return y <= win_yhi;
         STAGE_RIGHT: return x <= win_xhi;
         default: return y >= win_ylo;
      endcase
   endfunction

   function automatic void push_clipped(longint x, longint y, logic last, logic none);
      clip_vertex_type c;
      c.x = coord_type'(x);
      c.y = coord_type'(y);
      c.last = last;
      c.none = none;
      clipped_q.insert(clipped_q.size(), c);
   endfunction

   function automatic void pass_on(int s, longint x, longint y);
      if (s + 1 < NUM_STAGES) begin
         emitted[s] = 1;
         stage_point(s + 1, x, y);
      end else begin
         if (emitted[s]) push_clipped(hold_x, hold_y, 0, 0);
         hold_x = x;
         hold_y = y;
         emitted[s] = 1;
      end
   endfunction

   function automatic void clip_edge(int s, longint ax, longint ay, longint bx, longint by);
      bit ain, bin;
      longint cx, cy;
      ain = in_half(s, ax, ay);
      bin = in_half(s, bx, by);
      if (ain != bin) begin
         if (s == STAGE_LEFT || s == STAGE_RIGHT) begin
            cx = (s == STAGE_LEFT) ? win_xlo : win_xhi;
            cy = cross_at(ax, ay, bx, by, cx);
         end else begin
            cy = (s == STAGE_TOP) ? win_yhi : win_ylo;
            cx = cross_at(ay, ax, by, bx, cy);
         end
         pass_on(s, cx, cy);
      end
      if (bin) pass_on(s, bx, by);
   endfunction

   function automatic void stage_point(int s, longint x, longint y);
      if (!seen[s]) begin
         fx[s] = x;
         fy[s] = y;
         seen[s] = 1;
      end else begin
         clip_edge(s, px[s], py[s], x, y);
      end
      px[s] = x;
      py[s] = y;
   endfunction

   function automatic void predict_clip(poly_vertex_type v);
      longint a, b;
      a = reg_xmin; b = reg_xmax;
      win_xlo = a < b ? a : b; win_xhi = a < b ? b : a;
      a = reg_ymin; b = reg_ymax;
      win_ylo = a < b ? a : b; win_yhi = a < b ? b : a;
      stage_point(0, v.x, v.y);
      if (v.last) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (seen[s]) clip_edge(s, px[s], py[s], fx[s], fy[s]);
            seen[s] = 0;
         end
         if (emitted[NUM_STAGES-1]) push_clipped(hold_x, hold_y, 1, 0);
         else push_clipped(0, 0, 1, 1);
         for (int s = 0; s < NUM_STAGES; s++) emitted[s] = 0;
      end
   endfunction

   // the caller drops csr_wr_en after its last write
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_X_MIN: reg_xmin = val;
         CSR_X_MAX: reg_xmax = val;
         CSR_Y_MIN: reg_ymin = val;
         CSR_Y_MAX: reg_ymax = val;
         default: ;
      endcase
   endtask

   task automatic set_window(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d);
      wait (clipped_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_X_MIN, a);
      write_reg(CSR_X_MAX, b);
      write_reg(CSR_Y_MIN, c);
      write_reg(CSR_Y_MAX, d);
      write_reg(CSR_UNUSED, 16'hffff);
      csr_wr_en <= 0;
   endtask

   task automatic send_vertex(poly_vertex_type v, logic chk, clip_vertex_type e);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_vert_x <= v.x;
      req_vert_y <= v.y;
      req_last_vertex <= v.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_clip(v);
      if (v.last) begin
         fixed_q.insert(fixed_q.size(), chk);
         fixed_val_q.insert(fixed_val_q.size(), e);
      end
   endtask

   function automatic poly_vertex_type pv(int x, int y, logic last);
      poly_vertex_type v;
      v.x = coord_type'(x); v.y = coord_type'(y); v.last = last;
      return v;
   endfunction

   function automatic clip_vertex_type cv(int x, int y, logic last, logic none);
      clip_vertex_type c;
      c.x = coord_type'(x); c.y = coord_type'(y); c.last = last; c.none = none;
      return c;
   endfunction

   task automatic add_row(poly_vertex_type v, logic chk, clip_vertex_type e);
      stim_row_type r;
      r.v = v; r.chk = chk; r.exp = e;
      rows.insert(rows.size(), r);
   endtask

   task automatic random_polygon(int span);
      int n;
      logic last;
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
         last = (i == n - 1);
         if ($urandom_range(0, 9) == 0)
            send_vertex(pv($urandom, $urandom, last), 0, '0);
         else
            send_vertex(pv(int'($urandom_range(0, 2 * span)) - span / 2,
                           int'($urandom_range(0, 2 * span)) - span / 2, last), 0, '0);
      end
   endtask

   // response side
   always @(posedge clock) begin
      clip_vertex_type got, want, row_exp;
      logic chk;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_x, rsp_out_y, rsp_out_last, rsp_no_vertex};
         if (clipped_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction %h", got);
         end else begin
            want = clipped_q.pop_front();
            if (want.last && fixed_q.size() > 0) begin
               chk = fixed_q.pop_front();
               row_exp = fixed_val_q.pop_front();
               if (chk && row_exp != got) begin
                  errors++;
                  if (errors <= 10)
                     $display("table row expected %h got %h", row_exp, got);
               end
            end
            if (got != want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch x %0d/%0d y %0d/%0d last %b/%b none %b/%b",
                           want.x, got.x, want.y, got.y, want.last, got.last,
                           want.none, got.none);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (long_hold) begin
         rsp_stall <= 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_stall <= 1;
      end else if (rsp_stall && $urandom_range(0, 2) != 0) begin
         rsp_stall <= ($urandom_range(0, 30) == 0) ? 1 : ($urandom_range(0, 1) == 0);
      end else begin
         rsp_stall <= 0;
      end
   end

   initial begin
      @(posedge clock);
      wait (!reset);
      repeat (300) @(posedge clock);
      long_hold = 1;
      repeat (600) @(posedge clock);
      long_hold = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || long_hold)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reg_xmin = X_MIN_RST; reg_xmax = X_MAX_RST;
      reg_ymin = Y_MIN_RST; reg_ymax = Y_MAX_RST;
      for (int s = 0; s < NUM_STAGES; s++) begin
         seen[s] = 0; emitted[s] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed table: single vertices, extremes, a crossing square, two triangles and a two-vertex polygon
      add_row(pv(0, 0, 1), 1, cv(0, 0, 1, 0));
      add_row(pv(511, 511, 1), 1, cv(511, 511, 1, 0));
      add_row(pv(-32768, 0, 1), 1, cv(0, 0, 1, 1));
      add_row(pv(32767, 32767, 1), 1, cv(0, 0, 1, 1));
      add_row(pv(0, -1, 1), 1, cv(0, 0, 1, 1));
      add_row(pv(-100, -100, 0), 0, '0);
      add_row(pv(600, -100, 0), 0, '0);
      add_row(pv(600, 600, 0), 0, '0);
      add_row(pv(-100, 600, 1), 0, '0);
      add_row(pv(-32768, -32768, 0), 0, '0);
      add_row(pv(32767, -32768, 0), 0, '0);
      add_row(pv(0, 32767, 1), 0, '0);
      add_row(pv(-5, 10, 0), 0, '0);
      add_row(pv(-1, 20, 1), 1, cv(0, 0, 1, 1));
      add_row(pv(10, 10, 0), 0, '0);
      add_row(pv(700, 300, 0), 0, '0);
      add_row(pv(300, 700, 1), 0, '0);
      foreach (rows[i]) send_vertex(rows[i].v, rows[i].chk, rows[i].exp);
      req_valid <= 0;
      set_window(16'sd200, -16'sd50, 16'sd300, 16'sd10);
      for (int i = 0; i < 20; i++) random_polygon(400);
      req_valid <= 0;
      set_window(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      for (int i = 0; i < 15; i++) random_polygon(60000);
      req_valid <= 0;
      set_window(16'sd7, 16'sd7, -16'sd3, -16'sd3);
      for (int i = 0; i < 10; i++) random_polygon(30);
      req_valid <= 0;
      set_window(-16'sd1000, 16'sd1000, -16'sd500, 16'sd2000);
      for (int i = 0; i < 20; i++) random_polygon(4000);
      req_valid <= 0;
      wait (clipped_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ sim.f @@
sv/rpc_pkg.sv
sv/rpc_clip_cell.sv
sv/rpc_sink.sv
sv/rect_polygon_clipper.sv
test/tb.sv
